// File: src/ethp_pkg.sv
// Shared constants and types for the Ethernet/IPv4/TCP/UDP header parser.
`timescale 1ns / 1ps

package ethp_pkg;

  localparam int LEN_BITS_DEF = 16;

  localparam int ETH_HDR    = 14;
  localparam int IP_MIN     = 20;
  localparam int TCP_MIN    = 20;
  localparam int UDP_HDR    = 8;
  localparam int DMAC_END   = 6;
  localparam int SMAC_END   = 12;
  localparam int IP_TTL     = 8;
  localparam int IP_PROTO   = 9;
  localparam int IP_SIP     = 12;
  localparam int IP_DIP     = 16;
  localparam int L4_PORTS   = 4;
  localparam int TCP_SEQACK = 12;
  localparam int TCP_DOFF   = 12;
  localparam int TCP_FLAGS  = 13;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [3:0]  NIBBLE_MSK = 4'hF;

  typedef enum logic [2:0] {
    ST_NON_IP    = 3'd0,
    ST_IP_OTHER  = 3'd1,
    ST_TCP       = 3'd2,
    ST_UDP       = 3'd3,
    ST_MALFORMED = 3'd4
  } status_t;

  // first member sits in the top bits, so status ends up at bit 0
  typedef struct packed {
    logic [15:0] pay_len;
    logic [4:0]  tcp_flags;
    logic [31:0] ack_number;
    logic [31:0] seq_number;
    logic [15:0] l4_dport;
    logic [15:0] l4_sport;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [15:0] ttl_and_protocol;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    status_t     status;
  } result_t;

endpackage

// File: src/eth_ipv4_tcp_udp_header_parser.sv
// Ethernet/IPv4/TCP/UDP header parser: byte stream in, one header summary per packet out.
`timescale 1ns / 1ps

// Path: out_tvalid is registered; a packet's last byte passes through the input register, then
// the field capture and status logic into the result register.
// Throughput: one byte per cycle; a new byte is taken while a result waits on out_tready.
// The input stage stalls only on a last byte while the result register is still full.
// Reset: synchronous, active low; clears valid flags, byte counter and all field registers.
module eth_ipv4_tcp_udp_header_parser
  import ethp_pkg::*;
#(
  parameter int LENGTH_BITS = LEN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] data_byte
  input  logic           in_tlast,   // last_byte
  output logic           out_tvalid,
  input  logic           out_tready,
  // [2:0] status, [50:3] dst_mac, [98:51] src_mac, [114:99] ttl_and_protocol,
  // [146:115] src_ip, [178:147] dst_ip, [194:179] l4_sport, [210:195] l4_dport,
  // [242:211] seq_number, [274:243] ack_number, [279:275] tcp_flags,
  // [295:280] pay_len
  output logic [295:0]   out_tdata
);

  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

  typedef logic [LENGTH_BITS-1:0] cnt_t;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       take;

  // field capture state
  cnt_t        cnt_r, cnt_nxt;
  logic [5:0]  ihl_r, ihl_nxt;
  logic [5:0]  l4hb_r, l4hb_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [47:0] dmac_r, dmac_nxt;
  logic [47:0] smac_r, smac_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] sip_r, sip_nxt;
  logic [31:0] dip_r, dip_nxt;
  logic [31:0] ports_r, ports_nxt;
  logic [63:0] seqack_r, seqack_nxt;
  logic [4:0]  flags_r, flags_nxt;

  // result register
  logic    out_vld_r;
  result_t out_data_r, res;

  cnt_t q, r, lq, l4, payload;
  logic is_tcp, is_udp;

  assign take      = in_vld_r && (!in_last_r || !out_vld_r || out_tready);
  assign in_tready = !in_vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // per-byte capture
  always_comb begin
    cnt_nxt    = cnt_r;
    ihl_nxt    = ihl_r;
    l4hb_nxt   = l4hb_r;
    etype_nxt  = etype_r;
    dmac_nxt   = dmac_r;
    smac_nxt   = smac_r;
    ttl_nxt    = ttl_r;
    proto_nxt  = proto_r;
    sip_nxt    = sip_r;
    dip_nxt    = dip_r;
    ports_nxt  = ports_r;
    seqack_nxt = seqack_r;
    flags_nxt  = flags_r;
    q      = cnt_r - LENGTH_BITS'(ETH_HDR);
    r      = q - LENGTH_BITS'(ihl_r);
    is_tcp = proto_r == PROTO_TCP;
    is_udp = proto_r == PROTO_UDP;
    if (cnt_r != COUNT_MAX) begin
      cnt_nxt = cnt_r + LENGTH_BITS'(1);
      if (cnt_r < LENGTH_BITS'(DMAC_END)) begin
        dmac_nxt = {dmac_r[39:0], in_byte_r};
      end else if (cnt_r < LENGTH_BITS'(SMAC_END)) begin
        smac_nxt = {smac_r[39:0], in_byte_r};
      end else if (cnt_r < LENGTH_BITS'(ETH_HDR)) begin
        etype_nxt = {etype_r[7:0], in_byte_r};
      end else if (etype_r == ETYPE_IPV4) begin
        if (q == '0) begin
          ihl_nxt = {in_byte_r[3:0] & NIBBLE_MSK, 2'b00};
        end else if (q == LENGTH_BITS'(IP_TTL)) begin
          ttl_nxt = in_byte_r;
        end else if (q == LENGTH_BITS'(IP_PROTO)) begin
          proto_nxt = in_byte_r;
        end else if (q >= LENGTH_BITS'(IP_SIP) && q < LENGTH_BITS'(IP_DIP)) begin
          sip_nxt = {sip_r[23:0], in_byte_r};
        end else if (q >= LENGTH_BITS'(IP_DIP) && q < LENGTH_BITS'(IP_MIN)) begin
          dip_nxt = {dip_r[23:0], in_byte_r};
        end
        if (ihl_r >= 6'(IP_MIN) && q >= LENGTH_BITS'(ihl_r)) begin
          if ((is_tcp || is_udp) && r < LENGTH_BITS'(L4_PORTS)) begin
            ports_nxt = {ports_r[23:0], in_byte_r};
          end else if (is_tcp && r < LENGTH_BITS'(TCP_SEQACK)) begin
            seqack_nxt = {seqack_r[55:0], in_byte_r};
          end else if (is_tcp && r == LENGTH_BITS'(TCP_DOFF)) begin
            l4hb_nxt = {in_byte_r[7:4] & NIBBLE_MSK, 2'b00};
          end else if (is_tcp && r == LENGTH_BITS'(TCP_FLAGS)) begin
            flags_nxt = in_byte_r[4:0];
          end
        end
      end
    end
  end

  // end-of-packet status and payload length
  always_comb begin
    lq      = cnt_nxt - LENGTH_BITS'(ETH_HDR);
    l4      = lq - LENGTH_BITS'(ihl_nxt);
    payload = '0;
    if (cnt_nxt < LENGTH_BITS'(ETH_HDR)) begin
      res.status = ST_MALFORMED;
    end else if (etype_nxt != ETYPE_IPV4) begin
      res.status = ST_NON_IP;
    end else if (lq < LENGTH_BITS'(IP_MIN) || ihl_nxt < 6'(IP_MIN) ||
                 lq < LENGTH_BITS'(ihl_nxt)) begin
      res.status = ST_MALFORMED;
    end else if (proto_nxt == PROTO_TCP) begin
      if (l4 < LENGTH_BITS'(TCP_MIN)) begin
        res.status = ST_MALFORMED;
      end else begin
        res.status = ST_TCP;
        if (l4 > LENGTH_BITS'(l4hb_nxt)) begin
          payload = l4 - LENGTH_BITS'(l4hb_nxt);
        end
      end
    end else if (proto_nxt == PROTO_UDP) begin
      if (l4 < LENGTH_BITS'(UDP_HDR)) begin
        res.status = ST_MALFORMED;
      end else begin
        res.status = ST_UDP;
        payload    = l4 - LENGTH_BITS'(UDP_HDR);
      end
    end else begin
      res.status = ST_IP_OTHER;
    end
    res.dst_mac          = dmac_nxt;
    res.src_mac          = smac_nxt;
    res.ttl_and_protocol = {ttl_nxt, proto_nxt};
    res.src_ip           = sip_nxt;
    res.dst_ip           = dip_nxt;
    res.l4_sport         = ports_nxt[31:16];
    res.l4_dport         = ports_nxt[15:0];
    res.seq_number       = seqack_nxt[63:32];
    res.ack_number       = seqack_nxt[31:0];
    res.tcp_flags        = flags_nxt;
    res.pay_len          = 16'(payload);
  end

  // state clears after every packet
  always_ff @(posedge clk) begin
    if (!rst_n || (take && in_last_r)) begin
      cnt_r    <= '0;
      ihl_r    <= '0;
      l4hb_r   <= '0;
      etype_r  <= '0;
      dmac_r   <= '0;
      smac_r   <= '0;
      ttl_r    <= '0;
      proto_r  <= '0;
      sip_r    <= '0;
      dip_r    <= '0;
      ports_r  <= '0;
      seqack_r <= '0;
      flags_r  <= '0;
    end else if (take) begin
      cnt_r    <= cnt_nxt;
      ihl_r    <= ihl_nxt;
      l4hb_r   <= l4hb_nxt;
      etype_r  <= etype_nxt;
      dmac_r   <= dmac_nxt;
      smac_r   <= smac_nxt;
      ttl_r    <= ttl_nxt;
      proto_r  <= proto_nxt;
      sip_r    <= sip_nxt;
      dip_r    <= dip_nxt;
      ports_r  <= ports_nxt;
      seqack_r <= seqack_nxt;
      flags_r  <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_last_r) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && in_last_r |=> cnt_r == '0)
    else $error("byte counter not cleared after end of packet");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_tready |-> !(take && in_last_r))
    else $error("pending result overwritten");

  a_payload_l4: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.pay_len != '0 |->
      out_data_r.status == ST_TCP || out_data_r.status == ST_UDP)
    else $error("payload length on a packet without L4 header");

  a_tcp_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r.status != ST_TCP && out_data_r.status != ST_MALFORMED |->
      out_data_r.seq_number == '0 && out_data_r.ack_number == '0 &&
      out_data_r.tcp_flags == '0)
    else $error("TCP fields set on a non-TCP packet");

endmodule
